[rtl/pgm_pkg.sv]
// ============================================================================
// pgm_pkg - shared types and constants for polynomial gene mutation
// Fixed-point formats, the item record that rides along the pipeline and the
// square-root chain used by the exp2 unit.
// ============================================================================
package pgm_pkg;

    // Internal gene width; ratios and powers are unsigned Q1.30
    localparam int GW     = 32;
    localparam int FXB    = 30;
    localparam int LGB    = 24;
    localparam int FXW    = FXB + 1;
    localparam int LGW    = 29;
    localparam int E1W    = 17;
    localparam int ETA_W  = 16;

    localparam logic [FXW-1:0] FX_ONE  = FXW'(1) << FXB;
    localparam logic [FXW-1:0] FX_HALF = FXW'(1) << (FXB - 1);

    // Configuration register indexes
    localparam logic REG_MUT_RATE = 1'b0;
    localparam logic REG_DIST_IDX = 1'b1;

    typedef struct packed {
        logic signed [GW-1:0] y;
        logic signed [GW-1:0] yl;
        logic signed [GW-1:0] yu;
        logic [GW-1:0]        range;
        logic [FXW-1:0]       r;
        logic [E1W-1:0]       e1;
        logic                 low;
        logic                 mut;
        logic                 rerr;
        logic                 zx;
        logic                 zv;
    } item_t;

    // 2^(2^-(j+1)) in Q2.30: truncated integer square roots chained from 2.0
    function automatic logic [31:0] pgm_root(input int j);
        logic [63:0] root;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        root = 64'd1 << 31;
        for (int i = 0; i <= j; i++)
        begin
            v   = root << FXB;
            res = '0;
            b   = 64'd1 << 62;
            for (int t = 0; t < 32; t++)
            begin
                if (b > v)
                    b = b >> 2;
            end
            for (int t = 0; t < 32; t++)
            begin
                if (b != 0)
                begin
                    if (v >= res + b)
                    begin
                        v   = v - (res + b);
                        res = (res >> 1) + b;
                    end
                    else
                        res = res >> 1;
                    b = b >> 2;
                end
            end
            root = res;
        end
        return root[31:0];
    endfunction

endpackage

[rtl/pgm_div.sv]
// ============================================================================
// pgm_div - pipelined restoring divider
// One quotient bit per stage, most significant first; a side word travels
// with each operand pair.
// ============================================================================
module pgm_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int QB = 31,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QB-1:0] quo,
    output logic [PW-1:0] out_pay
);

    localparam int W = (NW > DW + QB) ? NW : DW + QB;

    logic [W-1:0]  rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB+1];
    logic [PW-1:0] pay_reg [QB+1];
    logic          vld_reg [QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= W'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        localparam int K = QB - s;
        logic [W-1:0]  shd;
        logic          ge;
        logic [W-1:0]  rem_next;
        logic [QB-1:0] quo_next;

        always_comb
        begin
            shd      = W'(den_reg[s-1]) << K;
            ge       = rem_reg[s-1] >= shd;
            rem_next = ge ? rem_reg[s-1] - shd : rem_reg[s-1];
            quo_next = quo_reg[s-1];
            quo_next[K] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_next;
                pay_reg[s] <= pay_reg[s-1];
            end
        end

        if (s < QB)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign quo       = quo_reg[QB];
    assign out_pay   = pay_reg[QB];

endmodule

[rtl/pgm_log2.sv]
// ============================================================================
// pgm_log2 - pipelined -log2 for Q1.30 values in (0, 1]
// Normalize, then one squaring step per stage; result is a Q.24 magnitude.
// ============================================================================
module pgm_log2 #(
    parameter int PW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [pgm_pkg::FXW-1:0] x_in,
    input  logic [PW-1:0]          in_pay,
    output logic                   out_valid,
    output logic [pgm_pkg::LGW-1:0] lg,
    output logic [PW-1:0]          out_pay
);

    import pgm_pkg::*;

    logic [FXW-1:0] x_reg  [LGB];
    logic [4:0]     n_reg  [LGB+1];
    logic [LGB-1:0] p_reg  [1:LGB];
    logic [PW-1:0]  pay_reg[LGB+2];
    logic           vld_reg[LGB+2];
    logic [LGW-1:0] lg_reg;
    logic [4:0]     nrm;

    // leading-zero count up to the 2^30 position
    always_comb
    begin
        nrm = '0;
        for (int b = 0; b < FXW; b++)
        begin
            if (x_in[b])
                nrm = 5'(FXB - b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= FXW'(x_in << nrm);
            n_reg[0]   <= nrm;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar s = 1; s <= LGB; s++)
    begin : g_sq
        logic [2*FXW-1:0] sq;
        logic [31:0]      t;
        logic [FXW-1:0]   x_next;
        logic [LGB-1:0]   p_prev;
        logic [LGB-1:0]   p_next;

        if (s == 1)
        begin : g_first
            assign p_prev = '0;
        end
        else
        begin : g_rest
            assign p_prev = p_reg[s-1];
        end

        always_comb
        begin
            sq     = (2*FXW)'(x_reg[s-1]) * (2*FXW)'(x_reg[s-1]);
            t      = 32'(sq >> FXB);
            x_next = t[31] ? t[31:1] : t[30:0];
            p_next = {p_prev[LGB-2:0], t[31]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[s]   <= p_next;
                n_reg[s]   <= n_reg[s-1];
                pay_reg[s] <= pay_reg[s-1];
            end
        end

        if (s < LGB)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                    x_reg[s] <= x_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[LGB+1] <= 1'b0;
        else if (en)
            vld_reg[LGB+1] <= vld_reg[LGB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_reg         <= {n_reg[LGB], {LGB{1'b0}}} - LGW'(p_reg[LGB]);
            pay_reg[LGB+1] <= pay_reg[LGB];
        end
    end

    assign out_valid = vld_reg[LGB+1];
    assign lg        = lg_reg;
    assign out_pay   = pay_reg[LGB+1];

endmodule

[rtl/pgm_exp2.sv]
// ============================================================================
// pgm_exp2 - pipelined 2^(-m) for a Q.24 magnitude, result in Q1.30
// The fraction is built from one square-root constant per stage.
// ============================================================================
module pgm_exp2 #(
    parameter int MW = 38,
    parameter int PW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [MW-1:0]          m,
    input  logic [PW-1:0]          in_pay,
    output logic                   out_valid,
    output logic [pgm_pkg::FXW-1:0] q,
    output logic [PW-1:0]          out_pay
);

    import pgm_pkg::*;

    localparam int NW = MW - LGB;

    logic [LGB-1:0] g_reg   [LGB];
    logic [31:0]    mant_reg[1:LGB];
    logic [4:0]     sh_reg  [LGB+1];
    logic           big_reg [LGB+1];
    logic           fz_reg  [LGB+1];
    logic [PW-1:0]  pay_reg [LGB+2];
    logic           vld_reg [LGB+2];
    logic [FXW-1:0] q_reg;
    logic [NW-1:0]  n_in;
    logic [LGB-1:0] f_in;

    assign n_in = m[MW-1:LGB];
    assign f_in = m[LGB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg[0]   <= LGB'((LGB+1)'(1) << LGB) - f_in;
            sh_reg[0]  <= 5'(n_in);
            big_reg[0] <= n_in >= NW'(31);
            fz_reg[0]  <= f_in == '0;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar s = 1; s <= LGB; s++)
    begin : g_mul
        localparam int K = LGB - s;
        localparam logic [31:0] RT = pgm_root(s - 1);
        logic [31:0] m_prev;
        logic [63:0] prod;
        logic [31:0] m_next;

        if (s == 1)
        begin : g_first
            assign m_prev = 32'(FX_ONE);
        end
        else
        begin : g_rest
            assign m_prev = mant_reg[s-1];
        end

        always_comb
        begin
            prod   = 64'(m_prev) * 64'(RT);
            m_next = g_reg[s-1][K] ? 32'(prod >> FXB) : m_prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mant_reg[s] <= m_next;
                sh_reg[s]   <= sh_reg[s-1];
                big_reg[s]  <= big_reg[s-1];
                fz_reg[s]   <= fz_reg[s-1];
                pay_reg[s]  <= pay_reg[s-1];
            end
        end

        if (s < LGB)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                    g_reg[s] <= g_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[LGB+1] <= 1'b0;
        else if (en)
            vld_reg[LGB+1] <= vld_reg[LGB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (big_reg[LGB])
                q_reg <= '0;
            else if (fz_reg[LGB])
                q_reg <= FX_ONE >> sh_reg[LGB];
            else
                q_reg <= FXW'(mant_reg[LGB] >> 1) >> sh_reg[LGB];
            pay_reg[LGB+1] <= pay_reg[LGB];
        end
    end

    assign out_valid = vld_reg[LGB+1];
    assign q         = q_reg;
    assign out_pay   = pay_reg[LGB+1];

endmodule

[rtl/polynomial_gene_mutation_core.sv]
// ============================================================================
// polynomial_gene_mutation_core - streaming polynomial mutation of one gene
// Decides mutation per gene, forms deltaq through log2/exp2 and divides,
// then moves and clamps the gene.
// ============================================================================
// Takes one gene word per clock while no result waits on m_tready and returns
// one result word per gene, in order. The pipeline chains two bit-per-stage
// dividers and two log2 and two exp2 units of 26 stages each.
// The whole pipeline holds while a result waits on m_tready; s_tready drops
// only then. Write the two configuration registers only while no gene is in
// flight.
module polynomial_gene_mutation_core #(
    parameter int DRAW_BITS = 16,
    parameter int GENE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // gene_value, lower_bound, upper_bound, apply_draw, variate_draw; zero pad
    input  logic [((3*GENE_BITS+2*DRAW_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // new_value; zero pad
    output logic [((GENE_BITS+7)/8)*8-1:0] m_tdata,
    // was_mutated, range_error
    output logic [1:0] m_tuser,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [((DRAW_BITS+1 > 16) ? DRAW_BITS+1 : 16)-1:0] cfg_data
);

    import pgm_pkg::*;

    localparam int OUT_W = ((GENE_BITS + 7) / 8) * 8;
    localparam int PW    = $bits(item_t);
    localparam int RSH_L = (DRAW_BITS <= FXB) ? FXB - DRAW_BITS : 0;
    localparam int RSH_R = (DRAW_BITS <= FXB) ? 0 : DRAW_BITS - FXB;

    logic [DRAW_BITS:0] rate_reg;
    logic [ETA_W-1:0]   eta_reg;
    logic               adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
            eta_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MUT_RATE: rate_reg <= cfg_data[DRAW_BITS:0];
                REG_DIST_IDX: eta_reg  <= cfg_data[ETA_W-1:0];
                default:      rate_reg <= rate_reg;
            endcase
        end
    end

    // ---- stage 1: capture the word ----
    logic                  vld1_reg;
    logic signed [GW-1:0]  y1_reg, yl1_reg, yu1_reg;
    logic [DRAW_BITS-1:0]  apl1_reg, rd1_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (adv)
            vld1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y1_reg   <= GW'($signed(s_tdata[GENE_BITS-1:0]));
            yl1_reg  <= GW'($signed(s_tdata[2*GENE_BITS-1:GENE_BITS]));
            yu1_reg  <= GW'($signed(s_tdata[3*GENE_BITS-1:2*GENE_BITS]));
            apl1_reg <= s_tdata[3*GENE_BITS+DRAW_BITS-1:3*GENE_BITS];
            rd1_reg  <= s_tdata[3*GENE_BITS+2*DRAW_BITS-1:3*GENE_BITS+DRAW_BITS];
        end
    end

    // ---- stage 2: decide, range and distance to the bound opposite the move ----
    logic           vld2_reg;
    item_t          it2_reg, it2_next;
    logic [GW-1:0]  num2_reg, num2_next;
    logic [FXW-1:0] r_fx;

    assign r_fx = (DRAW_BITS <= FXB) ? FXW'(64'(rd1_reg) << RSH_L)
                                     : FXW'(64'(rd1_reg) >> RSH_R);

    always_comb
    begin
        it2_next.y     = y1_reg;
        it2_next.yl    = yl1_reg;
        it2_next.yu    = yu1_reg;
        it2_next.range = GW'(yu1_reg - yl1_reg);
        it2_next.r     = r_fx;
        it2_next.e1    = E1W'(eta_reg) + E1W'(256);
        it2_next.low   = r_fx <= FX_HALF;
        it2_next.rerr  = yu1_reg <= yl1_reg;
        it2_next.mut   = !it2_next.rerr && ({1'b0, apl1_reg} < rate_reg);
        it2_next.zx    = 1'b0;
        it2_next.zv    = 1'b0;
        // distance from the clamped gene to the bound opposite the side of the move
        priority if (y1_reg < yl1_reg)
            num2_next = it2_next.low ? it2_next.range : '0;
        else if (y1_reg > yu1_reg)
            num2_next = it2_next.low ? '0 : it2_next.range;
        else
            num2_next = it2_next.low ? GW'(yu1_reg - y1_reg) : GW'(y1_reg - yl1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (adv)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it2_reg  <= it2_next;
            num2_reg <= num2_next;
        end
    end

    // ---- xy = num / range ----
    logic           d1_vld;
    logic [FXW-1:0] xy;
    item_t          d1_it, l1_in_it;
    logic [FXW-1:0] l1_x;

    pgm_div #(.NW(GW + FXB), .DW(GW), .QB(FXW), .PW(PW)) u_div_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (vld2_reg),
        .num      ({num2_reg, {FXB{1'b0}}}),
        .den      (it2_reg.range),
        .in_pay   (it2_reg),
        .out_valid(d1_vld),
        .quo      (xy),
        .out_pay  (d1_it)
    );

    always_comb
    begin
        l1_in_it    = d1_it;
        l1_in_it.zx = xy == '0;
        l1_x        = (xy == '0) ? FX_ONE : ((xy > FX_ONE) ? FX_ONE : xy);
    end

    // ---- p = xy^e1 ----
    logic           lg1_vld;
    logic [LGW-1:0] lg1;
    item_t          lg1_it;

    pgm_log2 #(.PW(PW)) u_log_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (d1_vld),
        .x_in     (l1_x),
        .in_pay   (l1_in_it),
        .out_valid(lg1_vld),
        .lg       (lg1),
        .out_pay  (lg1_it)
    );

    logic                  vld4_reg;
    item_t                 it4_reg;
    logic [LGW+FXB-21-1:0] m4_reg;
    logic [LGW+E1W-1:0]    m4_prod;

    assign m4_prod = (LGW+E1W)'(lg1) * (LGW+E1W)'(lg1_it.e1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld4_reg <= 1'b0;
        else if (adv)
            vld4_reg <= lg1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_reg  <= ($bits(m4_reg))'(m4_prod >> 8);
            it4_reg <= lg1_it;
        end
    end

    logic           e1_vld;
    logic [FXW-1:0] p_raw;
    item_t          e1_it;

    pgm_exp2 #(.MW($bits(m4_reg)), .PW(PW)) u_exp_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (vld4_reg),
        .m        (m4_reg),
        .in_pay   (it4_reg),
        .out_valid(e1_vld),
        .q        (p_raw),
        .out_pay  (e1_it)
    );

    // ---- val = a + c * p ----
    logic           vld5_reg;
    item_t          it5_reg;
    logic [FXW-1:0] a5_reg, pr5_reg;
    logic [FXW-1:0] pe, a_low, a_hi, c_sel;
    logic [2*FXW-1:0] cp;

    always_comb
    begin
        pe    = e1_it.zx ? '0 : p_raw;
        a_low = FXW'({e1_it.r, 1'b0});
        a_hi  = FXW'({FX_ONE - e1_it.r, 1'b0});
        c_sel = e1_it.low ? FX_ONE - a_low : a_low - FX_ONE;
        cp    = (2*FXW)'(c_sel) * (2*FXW)'(pe);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld5_reg <= 1'b0;
        else if (adv)
            vld5_reg <= e1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a5_reg  <= e1_it.low ? a_low : a_hi;
            pr5_reg <= FXW'(cp >> FXB);
            it5_reg <= e1_it;
        end
    end

    logic           vld6_reg;
    item_t          it6_reg, it6_next;
    logic [FXW-1:0] x6_reg, x6_next;
    logic [FXW:0]   val;

    always_comb
    begin
        val         = (FXW+1)'(a5_reg) + (FXW+1)'(pr5_reg);
        it6_next    = it5_reg;
        it6_next.zv = val == '0;
        priority if (val == '0)
            x6_next = FX_ONE;
        else if (val > (FXW+1)'(FX_ONE))
            x6_next = FX_ONE;
        else
            x6_next = FXW'(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld6_reg <= 1'b0;
        else if (adv)
            vld6_reg <= vld5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x6_reg  <= x6_next;
            it6_reg <= it6_next;
        end
    end

    // ---- q = val^(1/e1) ----
    logic           lg2_vld;
    logic [LGW-1:0] lg2;
    item_t          lg2_it;

    pgm_log2 #(.PW(PW)) u_log_val (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (vld6_reg),
        .x_in     (x6_reg),
        .in_pay   (it6_reg),
        .out_valid(lg2_vld),
        .lg       (lg2),
        .out_pay  (lg2_it)
    );

    logic           d2_vld;
    logic [FXB-1:0] eq;
    item_t          d2_it;

    pgm_div #(.NW(LGW + 8), .DW(E1W), .QB(FXB), .PW(PW)) u_div_e1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (lg2_vld),
        .num      ({lg2, 8'd0}),
        .den      (lg2_it.e1),
        .in_pay   (lg2_it),
        .out_valid(d2_vld),
        .quo      (eq),
        .out_pay  (d2_it)
    );

    logic           e2_vld;
    logic [FXW-1:0] q_raw;
    item_t          e2_it;

    pgm_exp2 #(.MW(FXB), .PW(PW)) u_exp_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (d2_vld),
        .m        (eq),
        .in_pay   (d2_it),
        .out_valid(e2_vld),
        .q        (q_raw),
        .out_pay  (e2_it)
    );

    // ---- step = (1 - q) * range ----
    logic             vld7_reg;
    item_t            it7_reg;
    logic [GW-1:0]    st7_reg;
    logic [FXW-1:0]   dq;
    logic [FXW+GW-1:0] sp;

    always_comb
    begin
        dq = FX_ONE - (e2_it.zv ? '0 : q_raw);
        sp = (FXW+GW)'(dq) * (FXW+GW)'(e2_it.range);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld7_reg <= 1'b0;
        else if (adv)
            vld7_reg <= e2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st7_reg <= GW'(sp >> FXB);
            it7_reg <= e2_it;
        end
    end

    // ---- move, clamp and select ----
    logic signed [GW+1:0] ys, st, mv;
    logic signed [GW-1:0] res;
    logic [GENE_BITS-1:0] out_val_reg;
    logic [1:0]           out_flag_reg;
    logic                 out_vld_reg;

    always_comb
    begin
        ys = (GW+2)'(it7_reg.y);
        st = $signed({2'b00, st7_reg});
        mv = it7_reg.low ? ys - st : ys + st;
        priority if (mv > (GW+2)'(it7_reg.yu))
            res = it7_reg.yu;
        else if (mv < (GW+2)'(it7_reg.yl))
            res = it7_reg.yl;
        else
            res = GW'(mv);
        if (!it7_reg.mut)
            res = it7_reg.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_val_reg  <= GENE_BITS'(res);
            out_flag_reg <= {it7_reg.rerr, it7_reg.mut};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_val_reg);
    assign m_tuser  = out_flag_reg;

endmodule

[rtl/pgm_checker.sv]
// ============================================================================
// pgm_checker - port-level checks for polynomial_gene_mutation_core
// Watches the stream ports over time; bound to the top level below.
// ============================================================================
module pgm_checker #(
    parameter int OUT_W = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);

    // an empty range never reports a mutation
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("was_mutated and range_error both set");

    // hold the result word while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // the input side only stalls behind a waiting result
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result word shown during reset");

endmodule

bind polynomial_gene_mutation_core pgm_checker #(.OUT_W(OUT_W)) u_pgm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

[tb/polynomial_gene_mutation_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// polynomial_gene_mutation_core_tb - self-checking bench for gene mutation
// Streams genes with bounds and draws through the core under several rate
// and eta settings, predicts each result with a bit-exact fixed-point model
// and compares every output word in order, with random stalls on both sides.
// ============================================================================
module polynomial_gene_mutation_core_tb;
    import pgm_pkg::*;

    localparam longint ONE_Q30 = longint'(1) << 30;
    localparam longint ONE_Q24 = longint'(1) << 24;
    localparam int     DRAIN   = 200;
    localparam int     LIMIT   = 400000;

    typedef struct {
        logic [31:0] new_value;
        logic        was_mutated;
        logic        range_error;
    } gene_outcome_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we;
    logic         cfg_index;
    logic [16:0]  cfg_data;

    logic [127:0]  pending_genes[$];
    gene_outcome_t expected_genes[$];
    longint        sqrt_chain[24];
    longint        rate_reg;
    longint        eta_reg;
    int            src_idle_pct;
    int            snk_idle_pct;
    bit            hold_sender;
    int            mismatches;
    int            cycles;

    polynomial_gene_mutation_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // magnitude of log2(x) in Q.24, x in Q2.30 with 0 < x <= 1
    function automatic longint neg_log2(input longint x);
        longint n;
        longint p;
        n = 0;
        p = 0;
        while (x < ONE_Q30)
        begin
            x = x << 1;
            n++;
        end
        for (int i = 0; i < 24; i++)
        begin
            x = (x * x) >> 30;
            p = p << 1;
            if (x >= (ONE_Q30 << 1))
            begin
                x = x >> 1;
                p = p | 1;
            end
        end
        return (n << 24) - p;
    endfunction

    // 2^(-m) in Q2.30, m in Q.24
    function automatic longint pow2_neg(input longint m);
        longint n;
        longint g;
        longint mant;
        n = m >> 24;
        if (n >= 31)
            return 0;
        if ((m & (ONE_Q24 - 1)) == 0)
            return ONE_Q30 >> n;
        g = ONE_Q24 - (m & (ONE_Q24 - 1));
        mant = ONE_Q30;
        for (int i = 0; i < 24; i++)
        begin
            if (g[23-i])
                mant = (mant * sqrt_chain[i]) >> 30;
        end
        return (mant >> 1) >> n;
    endfunction

    function automatic gene_outcome_t mutate_gene(input logic [127:0] w);
        gene_outcome_t o;
        longint y, yl, yu, yc, range, e1, r, num, xy, p, val, q, step, res;
        longint a;
        bit low;
        y  = longint'($signed(w[31:0]));
        yl = longint'($signed(w[63:32]));
        yu = longint'($signed(w[95:64]));
        o.range_error = (yu <= yl);
        o.was_mutated = !o.range_error && (longint'(w[111:96]) < rate_reg);
        res = y;
        if (o.was_mutated)
        begin
            range = yu - yl;
            yc = (y < yl) ? yl : ((y > yu) ? yu : y);
            e1 = eta_reg + 256;
            r = longint'(w[127:112]) << 14;
            low = (r <= (ONE_Q30 >> 1));
            num = low ? (yu - yc) : (yc - yl);
            xy = (num << 30) / range;
            if (xy > ONE_Q30)
                xy = ONE_Q30;
            p = (xy == 0) ? 0 : pow2_neg((neg_log2(xy) * e1) >> 8);
            if (low)
            begin
                a = r << 1;
                val = a + (((ONE_Q30 - a) * p) >> 30);
            end
            else
                val = ((ONE_Q30 - r) << 1) + ((((r << 1) - ONE_Q30) * p) >> 30);
            if (val > ONE_Q30)
                val = ONE_Q30;
            q = (val == 0) ? 0 : pow2_neg((neg_log2(val) << 8) / e1);
            step = ((ONE_Q30 - q) * range) >> 30;
            res = low ? y - step : y + step;
            if (res > yu)
                res = yu;
            if (res < yl)
                res = yl;
        end
        o.new_value = res[31:0];
        return o;
    endfunction

    function automatic logic [127:0] gene_word(input logic [31:0] y, input logic [31:0] lo,
                                               input logic [31:0] hi, input logic [15:0] ap,
                                               input logic [15:0] vd);
        return {vd, ap, hi, lo, y};
    endfunction

    function automatic logic [15:0] pick_draw();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h8001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] random_gene();
        logic [31:0] lo, hi, y, span;
        int kind;
        kind = $urandom_range(0, 99);
        lo = $urandom;
        case ($urandom_range(0, 3))
            0: span = $urandom_range(1, 16);
            1: span = $urandom_range(1, 32'h0010_0000);
            2: span = $urandom;
            default: span = $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        if ($signed(lo) > $signed(32'h7FFF_FFFF - span))
            lo = 32'h7FFF_FFFF - span;
        hi = lo + span;
        y = lo + $urandom_range(0, span);
        if (kind < 8)
            y = $urandom;
        else if (kind < 14)
        begin
            hi = $urandom;
            lo = $urandom;
        end
        else if (kind < 18)
            hi = lo;
        return gene_word(y, lo, hi, pick_draw(), pick_draw());
    endfunction

    task automatic write_reg(input logic idx, input logic [16:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MUT_RATE)
            rate_reg = longint'(value);
        else
            eta_reg = longint'(value[15:0]);
    endtask

    task automatic drain_all();
        while (pending_genes.size() != 0 || expected_genes.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // sender: hold the word until accepted, then advance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_genes.push_back(mutate_gene(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_genes.size() != 0 && !hold_sender
                    && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_genes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        gene_outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_genes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: value %h flags %b", m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_genes.pop_front();
                    if (m_tdata !== want.new_value || m_tuser[0] !== want.was_mutated
                        || m_tuser[1] !== want.range_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: expected %h m%b e%b, got %h m%b e%b",
                                     want.new_value, want.was_mutated, want.range_error,
                                     m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        longint chain;
        logic [16:0] rates[6];
        logic [16:0] etas[6];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MUT_RATE;
        cfg_data = '0;
        rate_reg = 0;
        eta_reg = 0;
        src_idle_pct = 12;
        snk_idle_pct = 67;
        hold_sender = 1'b0;
        mismatches = 0;
        cycles = 0;
        chain = ONE_Q30 << 1;
        for (int i = 0; i < 24; i++)
        begin
            chain = int_sqrt(chain << 30);
            sqrt_chain[i] = chain;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, empty range, pass-through, out-of-bounds gene
        write_reg(REG_MUT_RATE, 17'd65536);
        write_reg(REG_DIST_IDX, 17'd0);
        pending_genes.push_back(gene_word(32'h0001_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'h0000));
        pending_genes.push_back(gene_word(32'h0001_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'hFFFF, 16'hFFFF));
        pending_genes.push_back(gene_word(32'h0002_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h1234, 16'h8000));
        pending_genes.push_back(gene_word(32'h0002_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h1234, 16'h8001));
        pending_genes.push_back(gene_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          16'h0000, 16'h4000));
        pending_genes.push_back(gene_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                          16'h0000, 16'hC000));
        pending_genes.push_back(gene_word(32'h0000_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'h0100));
        pending_genes.push_back(gene_word(32'h0004_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'hFF00));
        pending_genes.push_back(gene_word(32'hFFF0_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'h2000));
        pending_genes.push_back(gene_word(32'h0100_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'hE000));
        pending_genes.push_back(gene_word(32'h0003_0000, 32'h0005_0000, 32'h0005_0000,
                                          16'h0000, 16'h1111));
        pending_genes.push_back(gene_word(32'hFFFF_FFFF, 32'h0005_0000, 32'h8000_0000,
                                          16'h0000, 16'h1111));
        pending_genes.push_back(gene_word(32'h0000_0005, 32'h0000_0000, 32'h0000_0001,
                                          16'h7777, 16'h3333));
        drain_all();
        write_reg(REG_MUT_RATE, 17'd0);
        pending_genes.push_back(gene_word(32'hFFF0_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'h0000, 16'h2000));
        pending_genes.push_back(gene_word(32'h0001_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'hFFFF, 16'hFFFF));
        drain_all();
        write_reg(REG_MUT_RATE, 17'h1FFFF);
        write_reg(REG_DIST_IDX, 17'hFFFF);
        pending_genes.push_back(gene_word(32'h0001_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'hFFFF, 16'h0001));
        pending_genes.push_back(gene_word(32'h0003_0000, 32'h0000_0000, 32'h0004_0000,
                                          16'hFFFF, 16'hFFFE));
        drain_all();

        rates = '{17'd65536, 17'd0, 17'd32768, 17'h1FFFF, 17'd40000, 17'd65535};
        etas  = '{17'd0, 17'hFFFF, 17'd5120, 17'hFFFF, 17'd512, 17'd1};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_MUT_RATE, rates[ph]);
            write_reg(REG_DIST_IDX, etas[ph]);
            src_idle_pct = (ph < 2) ? 12 : ((ph < 4) ? 67 : 0);
            snk_idle_pct = (ph < 2) ? 67 : ((ph < 4) ? 12 : 0);
            for (int n = 0; n < 142; n++)
                pending_genes.push_back(random_gene());
            if (ph == 4)
            begin
                // hold the sender until the pipeline is empty, then resume
                while (pending_genes.size() > 70)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (expected_genes.size() != 0 || s_tvalid)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_all();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/pgm_pkg.sv
rtl/pgm_div.sv
rtl/pgm_log2.sv
rtl/pgm_exp2.sv
rtl/polynomial_gene_mutation_core.sv
rtl/pgm_checker.sv
tb/polynomial_gene_mutation_core_tb.sv
